>>> src/lgns_pkg.sv
// Shared types, label codes and register indexes for the label grid smoother.
package lgns_pkg;

  localparam int LABEL_W   = 2;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 2;

  typedef logic [LABEL_W-1:0] label_t;

  localparam label_t LABEL_ROCK  = 2'd0;
  localparam label_t LABEL_WATER = 2'd1;
  localparam label_t LABEL_GRASS = 2'd2;

  localparam logic KIND_CELL = 1'b0;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WATER_RATIO = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRASS_RATIO = 2'd2;

  localparam logic [CFG_W-1:0] RATIO_RST = 9'd128;

  typedef struct packed {
    logic   kind;
    label_t cell_label;
  } in_item_t;

  typedef struct packed {
    label_t smoothed_label;
    logic   frame_last;
  } out_item_t;

  // One window column, index 0 is the top row.
  typedef logic [2:0][LABEL_W-1:0] col_t;

  typedef struct packed {
    logic   emit;
    logic   last;
    logic   real_cell;
    logic   single;
    logic   top_ok;
    logic   bot_ok;
    logic   left_ok;
    logic   right_ok;
    label_t label;
  } stage_ctrl_t;

  function automatic label_t clean_label(label_t lab);
    label_t res;
    if (lab == LABEL_WATER || lab == LABEL_GRASS) begin
      res = lab;
    end else begin
      res = LABEL_ROCK;
    end
    return res;
  endfunction

endpackage

>>> src/lgns_line_store.sv
// Two line memories holding the previous two rows of labels, with registered reads.
module lgns_line_store #(
  parameter int MAX_GRID = 256
) (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [$clog2(MAX_GRID)-1:0] rd_addr,
  input  logic                      wr_en,
  input  logic [$clog2(MAX_GRID)-1:0] wr_addr,
  input  lgns_pkg::label_t          wr_label,
  output lgns_pkg::label_t          upper_q,
  output lgns_pkg::label_t          middle_q
);

  lgns_pkg::label_t upper_mem  [0:MAX_GRID-1];
  lgns_pkg::label_t middle_mem [0:MAX_GRID-1];
  lgns_pkg::label_t upper_rd_r;
  lgns_pkg::label_t middle_rd_r;

  // The middle row moves up as the new row is written behind it.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      upper_rd_r  <= upper_mem[rd_addr];
      middle_rd_r <= middle_mem[rd_addr];
    end
    if (wr_en) begin
      upper_mem[wr_addr]  <= middle_rd_r;
      middle_mem[wr_addr] <= wr_label;
    end
  end

  assign upper_q  = upper_rd_r;
  assign middle_q = middle_rd_r;

endmodule

>>> src/lgns_ctrl.sv
// Configuration registers, raster position counters and the input stage register.
module lgns_ctrl #(
  parameter int MAX_GRID = 256
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  lgns_pkg::in_item_t               in_item,
  input  logic                             cfg_we,
  input  logic [lgns_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lgns_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic                             out_free,
  output logic                             rd_en,
  output logic [$clog2(MAX_GRID)-1:0]      rd_addr,
  output logic                             s1_adv,
  output lgns_pkg::stage_ctrl_t            s1_ctrl,
  output logic [$clog2(MAX_GRID)-1:0]      s1_col,
  output logic [lgns_pkg::CFG_W-1:0]       water_ratio,
  output logic [lgns_pkg::CFG_W-1:0]       grass_ratio
);

  localparam int CW       = $clog2(MAX_GRID);
  localparam int NW       = $clog2(MAX_GRID + 1);
  localparam int RW       = NW + 1;
  localparam int SIZE_RST = (MAX_GRID < 256) ? MAX_GRID : 256;

  logic [NW-1:0]                side_r, side_nxt;
  logic [lgns_pkg::CFG_W-1:0]   water_ratio_r, water_ratio_nxt;
  logic [lgns_pkg::CFG_W-1:0]   grass_ratio_r, grass_ratio_nxt;
  logic [CW-1:0]                in_col_r, in_col_nxt;
  logic [RW-1:0]                in_row_r, in_row_nxt;
  logic [CW-1:0]                out_col_r, out_col_nxt;
  logic [CW-1:0]                out_row_r, out_row_nxt;
  logic                         s1_valid_r, s1_valid_nxt;
  lgns_pkg::stage_ctrl_t        s1_r, s1_nxt;
  logic [CW-1:0]                s1_col_r, s1_col_nxt;

  logic                         in_acc;
  logic [NW-1:0]                side_m1;
  logic [NW-1:0]                size_clamped;
  logic                         complete;
  logic                         is_cell;
  logic                         take;
  logic                         emit;
  logic                         col_end;
  logic                         out_col_end;
  logic                         out_last;

  assign s1_adv   = s1_valid_r && (!s1_r.emit || out_free);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  assign side_m1     = side_r - NW'(1);
  assign complete    = in_row_r >= RW'(side_r);
  assign is_cell     = in_item.kind == lgns_pkg::KIND_CELL;
  assign take        = in_acc && (complete || is_cell);
  assign emit        = complete || (in_row_r >= RW'(2)) ||
                       (in_row_r == RW'(1) && in_col_r != '0);
  assign col_end     = NW'(in_col_r) == side_m1;
  assign out_col_end = NW'(out_col_r) == side_m1;
  assign out_last    = (NW'(out_row_r) == side_m1) && out_col_end;

  always_comb begin
    if (cfg_wdata == '0) begin
      size_clamped = NW'(1);
    end else if (int'(cfg_wdata) > MAX_GRID) begin
      size_clamped = NW'(MAX_GRID);
    end else begin
      size_clamped = NW'(cfg_wdata);
    end
  end

  always_comb begin
    side_nxt        = side_r;
    water_ratio_nxt = water_ratio_r;
    grass_ratio_nxt = grass_ratio_r;
    in_col_nxt      = in_col_r;
    in_row_nxt      = in_row_r;
    out_col_nxt     = out_col_r;
    out_row_nxt     = out_row_r;
    s1_valid_nxt    = s1_valid_r;
    s1_nxt          = s1_r;
    s1_col_nxt      = s1_col_r;

    if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end

    if (take) begin
      if (col_end) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + RW'(1);
      end else begin
        in_col_nxt = in_col_r + CW'(1);
      end
      if (emit) begin
        if (out_col_end) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + CW'(1);
        end else begin
          out_col_nxt = out_col_r + CW'(1);
        end
      end
      if (emit && out_last) begin
        in_col_nxt  = '0;
        in_row_nxt  = '0;
        out_col_nxt = '0;
        out_row_nxt = '0;
      end

      s1_valid_nxt       = 1'b1;
      s1_col_nxt         = in_col_r;
      s1_nxt.emit        = emit;
      s1_nxt.last        = out_last;
      s1_nxt.real_cell   = !complete;
      s1_nxt.single      = side_r == NW'(1);
      s1_nxt.top_ok      = out_row_r != '0;
      s1_nxt.bot_ok      = NW'(out_row_r) != side_m1;
      s1_nxt.left_ok     = out_col_r != '0;
      s1_nxt.right_ok    = !out_col_end;
      s1_nxt.label       = complete ? lgns_pkg::LABEL_ROCK :
                           lgns_pkg::clean_label(in_item.cell_label);
    end

    if (cfg_we) begin
      case (cfg_index)
        lgns_pkg::CFG_GRID_SIZE: begin
          side_nxt    = size_clamped;
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
        end
        lgns_pkg::CFG_WATER_RATIO: begin
          water_ratio_nxt = cfg_wdata;
        end
        lgns_pkg::CFG_GRASS_RATIO: begin
          grass_ratio_nxt = cfg_wdata;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r        <= NW'(SIZE_RST);
      water_ratio_r <= lgns_pkg::RATIO_RST;
      grass_ratio_r <= lgns_pkg::RATIO_RST;
      in_col_r      <= '0;
      in_row_r      <= '0;
      out_col_r     <= '0;
      out_row_r     <= '0;
      s1_valid_r    <= 1'b0;
    end else begin
      side_r        <= side_nxt;
      water_ratio_r <= water_ratio_nxt;
      grass_ratio_r <= grass_ratio_nxt;
      in_col_r      <= in_col_nxt;
      in_row_r      <= in_row_nxt;
      out_col_r     <= out_col_nxt;
      out_row_r     <= out_row_nxt;
      s1_valid_r    <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_r     <= s1_nxt;
    s1_col_r <= s1_col_nxt;
  end

  assign rd_en       = in_acc;
  assign rd_addr     = in_col_r;
  assign s1_ctrl     = s1_r;
  assign s1_col      = s1_col_r;
  assign water_ratio = water_ratio_r;
  assign grass_ratio = grass_ratio_r;

endmodule

>>> src/lgns_window.sv
// The 3x3 label window, neighbor counting, relabel decision and result register.
module lgns_window (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        s1_adv,
  input  lgns_pkg::stage_ctrl_t       s1_ctrl,
  input  lgns_pkg::label_t            upper_q,
  input  lgns_pkg::label_t            middle_q,
  input  logic [lgns_pkg::CFG_W-1:0]  water_ratio,
  input  logic [lgns_pkg::CFG_W-1:0]  grass_ratio,
  input  logic                        out_stall,
  output logic                        out_valid,
  output lgns_pkg::out_item_t         out_item,
  output logic                        out_free
);

  lgns_pkg::col_t [2:1]  win_r;
  lgns_pkg::col_t        new_col;
  lgns_pkg::col_t [2:0]  view;
  lgns_pkg::label_t      own_r;
  lgns_pkg::label_t      own;
  lgns_pkg::label_t      res;
  logic [2:0]            row_ok;
  logic [2:0]            col_ok;
  logic [3:0]            water_cnt;
  logic [3:0]            grass_cnt;
  logic [3:0]            total_cnt;
  logic [12:0]           water_thr;
  logic [12:0]           grass_thr;
  logic                  water_hit;
  logic                  grass_hit;
  logic                  out_valid_r;
  lgns_pkg::out_item_t   out_item_r;
  logic                  out_load;

  assign new_col = {s1_ctrl.label, middle_q, upper_q};

  // Left and center come from stored columns, the right one is arriving now.
  assign view   = {new_col, win_r[2], win_r[1]};
  assign row_ok = {s1_ctrl.bot_ok, 1'b1, s1_ctrl.top_ok};
  assign col_ok = {s1_ctrl.right_ok, 1'b1, s1_ctrl.left_ok};
  assign own    = win_r[2][1];

  always_comb begin
    water_cnt = '0;
    grass_cnt = '0;
    total_cnt = '0;
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        if (col_ok[c] && row_ok[r]) begin
          total_cnt = total_cnt + 4'd1;
          if (view[c][r] == lgns_pkg::LABEL_WATER) begin
            water_cnt = water_cnt + 4'd1;
          end
          if (view[c][r] == lgns_pkg::LABEL_GRASS) begin
            grass_cnt = grass_cnt + 4'd1;
          end
        end
      end
    end
  end

  assign water_thr = 13'(water_ratio) * 13'(total_cnt);
  assign grass_thr = 13'(grass_ratio) * 13'(total_cnt);
  assign water_hit = {1'b0, water_cnt, 8'd0} > water_thr;
  assign grass_hit = {1'b0, grass_cnt, 8'd0} > grass_thr;

  always_comb begin
    if (s1_ctrl.single) begin
      res = own_r;
    end else if (own != lgns_pkg::LABEL_WATER && water_hit) begin
      res = lgns_pkg::LABEL_WATER;
    end else if (own == lgns_pkg::LABEL_ROCK && grass_hit) begin
      res = lgns_pkg::LABEL_GRASS;
    end else begin
      res = own;
    end
  end

  assign out_free = !out_valid_r || !out_stall;
  assign out_load = s1_adv && s1_ctrl.emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        win_r <= {new_col, win_r[2]};
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_ctrl.real_cell) begin
      own_r <= s1_ctrl.label;
    end
    if (out_load) begin
      out_item_r.smoothed_label <= res;
      out_item_r.frame_last     <= s1_ctrl.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

>>> src/label_grid_neighbourhood_smoother.sv
// Top level of the 3x3 majority smoother for a raster stream of terrain labels.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall  in_item   (kind, cell_label)
//   out_     output     out_valid / out_stall out_item (smoothed_label, frame_last)
//   cfg_     input      cfg_we               cfg_index, cfg_wdata
//
// One item is accepted every cycle while in_stall is low; out_valid rises after the item
// completing a neighborhood passes through the input stage and the result register.
// The line memories have one read and one write port, which sets the one item per cycle.
// Reset clears the counters, the window and the valid flags; the line memories need no
// clearing pass. A stalled result holds the pipeline only when the next item also emits.
module label_grid_neighbourhood_smoother #(
  parameter int MAX_GRID = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  lgns_pkg::in_item_t              in_item,
  output logic                            out_valid,
  input  logic                            out_stall,
  output lgns_pkg::out_item_t             out_item,
  input  logic                            cfg_we,
  input  logic [lgns_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lgns_pkg::CFG_W-1:0]      cfg_wdata
);

  localparam int CW = $clog2(MAX_GRID);

  logic                        out_free;
  logic                        rd_en;
  logic [CW-1:0]               rd_addr;
  logic                        s1_adv;
  lgns_pkg::stage_ctrl_t       s1_ctrl;
  logic [CW-1:0]               s1_col;
  logic [lgns_pkg::CFG_W-1:0]  water_ratio;
  logic [lgns_pkg::CFG_W-1:0]  grass_ratio;
  lgns_pkg::label_t            upper_q;
  lgns_pkg::label_t            middle_q;

  lgns_ctrl #(
    .MAX_GRID (MAX_GRID)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .out_free    (out_free),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .s1_adv      (s1_adv),
    .s1_ctrl     (s1_ctrl),
    .s1_col      (s1_col),
    .water_ratio (water_ratio),
    .grass_ratio (grass_ratio)
  );

  lgns_line_store #(
    .MAX_GRID (MAX_GRID)
  ) u_line_store (
    .clk      (clk),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .wr_en    (s1_adv),
    .wr_addr  (s1_col),
    .wr_label (s1_ctrl.label),
    .upper_q  (upper_q),
    .middle_q (middle_q)
  );

  lgns_window u_window (
    .clk         (clk),
    .rst_n       (rst_n),
    .s1_adv      (s1_adv),
    .s1_ctrl     (s1_ctrl),
    .upper_q     (upper_q),
    .middle_q    (middle_q),
    .water_ratio (water_ratio),
    .grass_ratio (grass_ratio),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_item    (out_item),
    .out_free    (out_free)
  );

endmodule
